### rtl/core/mtf_pkg.sv
`timescale 1ns / 1ps

package mtf_pkg;

	// Alphabet and datapath widths
	localparam int ALPHABET_SIZE = 256;
	localparam int SYM_W         = 8;

	// Cells are OR-reduced in groups, then across groups
	localparam int GRP_SIZE = 16;
	localparam int NUM_GRPS = (ALPHABET_SIZE + GRP_SIZE - 1) / GRP_SIZE;

	// Configuration space
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_DECODE_MODE = 1'b0;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture item, restore identity order on block start
		logic match;   // per-cell compare
		logic reduce;  // per-group OR reduction
		logic select;  // cross-group OR reduction
		logic commit;  // move to front and load the output register
	} mtf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;  // output register full and not taken this cycle
	} mtf_status_t;

endpackage

### rtl/core/mtf_in_if.sv
`timescale 1ns / 1ps

interface mtf_in_if;
	logic                      valid;
	logic                      ready;
	logic [mtf_pkg::SYM_W-1:0] value_in;
	logic                      block_start;

	modport source (output valid, output value_in, output block_start, input ready);
	modport sink (input valid, input value_in, input block_start, output ready);
endinterface

### rtl/core/mtf_out_if.sv
`timescale 1ns / 1ps

interface mtf_out_if;
	logic                      valid;
	logic                      ready;
	logic [mtf_pkg::SYM_W-1:0] value_out;

	modport source (output valid, output value_out, input ready);
	modport sink (input valid, input value_out, output ready);
endinterface

### rtl/core/mtf_ctrl.sv
`timescale 1ns / 1ps

module mtf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output mtf_pkg::mtf_cmd_t    cmd,
	input  mtf_pkg::mtf_status_t status
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MATCH  = 5'b00010,
		ST_REDUCE = 5'b00100,
		ST_SELECT = 5'b01000,
		ST_SHIFT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = ST_SELECT;
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = ST_SHIFT;
			end
			ST_SHIFT: begin
				// hold until the output register has room
				if (!status.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/mtf_dpath.sv
`timescale 1ns / 1ps

module mtf_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mtf_pkg::mtf_cmd_t         cmd,
	output mtf_pkg::mtf_status_t      status,
	input  logic [mtf_pkg::SYM_W-1:0] value_in,
	input  logic                      block_start,
	input  logic                      decode_mode,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [mtf_pkg::SYM_W-1:0] value_out
);

	localparam int N  = mtf_pkg::ALPHABET_SIZE;
	localparam int W  = mtf_pkg::SYM_W;
	localparam int GS = mtf_pkg::GRP_SIZE;
	localparam int NG = mtf_pkg::NUM_GRPS;

	// Symbol list, one cell per position
	logic [W-1:0] cell_q [N];

	// Item captured at accept
	logic [W-1:0] val_s1;
	logic         mode_s1;
	logic         oor_s1;

	// Match vector
	logic [N-1:0] match_s2;

	// Per-group reductions
	logic [W-1:0] grp_pos_s3 [NG];
	logic [W-1:0] grp_sym_s3 [NG];
	logic [W-1:0] grp_pos_d  [NG];
	logic [W-1:0] grp_sym_d  [NG];

	// Final position and symbol
	logic [W-1:0] pos_s4;
	logic [W-1:0] sym_s4;
	logic [W-1:0] pos_d;
	logic [W-1:0] sym_d;

	logic [W-1:0] out_value_q;
	logic         out_valid_q;

	assign out_valid        = out_valid_q;
	assign value_out        = out_value_q;
	assign status.out_stall = out_valid_q && !out_ready;

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_s1  <= value_in;
			mode_s1 <= decode_mode;
			oor_s1  <= ({1'b0, value_in} >= (W+1)'(N));
		end
	end

	// Per-cell compare: by stored symbol when encoding, by position when decoding
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int i = 0; i < N; i++) begin
				match_s2[i] <= mode_s1 ? (W'(i) == val_s1) : (cell_q[i] == val_s1);
			end
		end
	end

	// Group reduction: the match vector is one-hot, so OR picks the hit
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_pos_d[g] = '0;
			grp_sym_d[g] = '0;
			for (int l = 0; l < GS; l++) begin
				if (g * GS + l < N) begin
					if (match_s2[g * GS + l]) begin
						grp_pos_d[g] = grp_pos_d[g] | W'(g * GS + l);
						grp_sym_d[g] = grp_sym_d[g] | cell_q[g * GS + l];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reduce) begin
			for (int g = 0; g < NG; g++) begin
				grp_pos_s3[g] <= grp_pos_d[g];
				grp_sym_s3[g] <= grp_sym_d[g];
			end
		end
	end

	// Cross-group reduction
	always_comb begin
		pos_d = '0;
		sym_d = '0;
		for (int g = 0; g < NG; g++) begin
			pos_d = pos_d | grp_pos_s3[g];
			sym_d = sym_d | grp_sym_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			pos_s4 <= pos_d;
			sym_s4 <= sym_d;
		end
	end

	// Symbol list: identity on reset and block start, move to front on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				cell_q[i] <= W'(i);
			end
		end else if (cmd.load && block_start) begin
			for (int i = 0; i < N; i++) begin
				cell_q[i] <= W'(i);
			end
		end else if (cmd.commit && !oor_s1) begin
			cell_q[0] <= sym_s4;
			for (int i = 1; i < N; i++) begin
				if (W'(i) <= pos_s4) begin
					cell_q[i] <= cell_q[i-1];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (oor_s1) begin
				out_value_q <= val_s1;
			end else begin
				out_value_q <= mode_s1 ? sym_s4 : pos_s4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/move_to_front_byte_coder.sv
`timescale 1ns / 1ps

// Channel   Modport  Payload                       Handshake
// in_ch     sink     value_in[7:0], block_start    valid / ready
// out_ch    source   value_out[7:0]                valid / ready
// apb       slave    decode_mode at byte addr 0    psel / penable / pready
//
// Each item passes from accept to result through accept, per-cell compare,
// group reduction, cross-group reduction, then move to front into the output
// register; the input takes no new item until that whole sequence completes.
// Reset restores the identity order in the cells and clears decode_mode.
// A full output register that is not taken holds the item in its last step;
// the input accepts again once that step completes.

module move_to_front_byte_coder (
	input  logic                          clk,
	input  logic                          arst_n,
	mtf_in_if.sink                        in_ch,
	mtf_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mtf_pkg::PADDR_W-1:0]   paddr,
	input  logic [mtf_pkg::PDATA_W-1:0]   pwdata,
	output logic [mtf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	mtf_pkg::mtf_cmd_t    cmd;
	mtf_pkg::mtf_status_t status;
	logic                 decode_mode_q;
	logic                 reg_sel;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[mtf_pkg::PADDR_W-1:2] == mtf_pkg::REG_DECODE_MODE);
	assign prdata  = reg_sel ? {{(mtf_pkg::PDATA_W-1){1'b0}}, decode_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			decode_mode_q <= pwdata[0];
		end
	end

	mtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.status   (status)
	);

	mtf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.value_in    (in_ch.value_in),
		.block_start (in_ch.block_start),
		.decode_mode (decode_mode_q),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.value_out   (out_ch.value_out)
	);

endmodule
